FILE: rtl/core/framed_record_crc_checker_top_macros.svh
// assertion macros for the framed record crc checker
// used by fcrc_hdr_track and framed_record_crc_checker_top, no other dependencies
`ifndef FRAMED_RECORD_CRC_CHECKER_TOP_MACROS_SVH
`define FRAMED_RECORD_CRC_CHECKER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// clocked check with a fixed message
`define FRC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("framed record checker assertion failed");
// clocked check with a caller supplied message
`define FRC_ASSERT_MSG(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`else
`define FRC_ASSERT(lbl, clk, rst, prop)
`define FRC_ASSERT_MSG(lbl, clk, rst, prop, msg)
`endif
`endif

FILE: rtl/core/fcrc_pkg.sv
// shared types, constants and the byte-wise crc function for the record checker
// no dependencies
package fcrc_pkg;

  localparam int POS_W = 17;
  localparam int CNT_W = 18;

  localparam logic [POS_W-1:0] POS_MAX     = 17'h1FFFF;
  localparam logic [POS_W-1:0] POS_VERSION = 17'd4;
  localparam logic [POS_W-1:0] POS_LENGTH  = 17'd6;
  localparam logic [POS_W-1:0] POS_GEN     = 17'd8;
  localparam logic [POS_W-1:0] CRC_SPAN    = 17'd12;
  localparam logic [POS_W-1:0] HDR_BYTES   = 17'd16;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MIGRATED = 3'd1;
  localparam logic [2:0] ST_SHORT    = 3'd2;
  localparam logic [2:0] ST_MAGIC    = 3'd3;
  localparam logic [2:0] ST_LENGTH   = 3'd4;
  localparam logic [2:0] ST_CRC      = 3'd5;
  localparam logic [2:0] ST_NEWER    = 3'd6;
  localparam logic [2:0] ST_OLDER    = 3'd7;

  // configuration register indexes
  localparam logic [1:0] REG_MAGIC    = 2'd0;
  localparam logic [1:0] REG_CUR_VER  = 2'd1;
  localparam logic [1:0] REG_MIN_VER  = 2'd2;
  localparam logic [1:0] REG_CAPACITY = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_payload;
    logic        record_done;
    logic [2:0]  status;
    logic [31:0] generation;
    logic [15:0] payload_length;
  } out_item_t;

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [15:0] current_version;
    logic [15:0] min_version;
    logic [15:0] payload_capacity;
  } cfg_regs_t;

  // header fields and crc as they stand once the current byte is taken in
  typedef struct packed {
    logic [31:0]      magic;
    logic [15:0]      version;
    logic [15:0]      length;
    logic [31:0]      generation;
    logic [31:0]      stored_crc;
    logic [31:0]      running_crc;
    logic [CNT_W-1:0] count;
    logic             payload;
  } hdr_view_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/fcrc_hdr_track.sv
// header capture, byte position and running crc for one record
// depends on fcrc_pkg and framed_record_crc_checker_top_macros.svh
`include "framed_record_crc_checker_top_macros.svh"

module fcrc_hdr_track (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  fcrc_pkg::in_item_t  item,
  output fcrc_pkg::hdr_view_t view
);

  logic [fcrc_pkg::POS_W-1:0] pos;
  logic [fcrc_pkg::POS_W-1:0] pos_next;
  logic [fcrc_pkg::POS_W-1:0] pos_off;
  logic [31:0] running_crc;
  logic [31:0] seen_magic;
  logic [15:0] seen_version;
  logic [15:0] seen_length;
  logic [31:0] seen_generation;
  logic [31:0] seen_crc;
  logic [4:0]  lane32;
  logic [3:0]  lane16;

  always_comb begin
    view.magic       = seen_magic;
    view.version     = seen_version;
    view.length      = seen_length;
    view.generation  = seen_generation;
    view.stored_crc  = seen_crc;
    view.payload     = 1'b0;
    lane32           = {pos[1:0], 3'b000};
    lane16           = {pos[0], 3'b000};
    pos_off          = pos - fcrc_pkg::HDR_BYTES;

    if (pos < fcrc_pkg::POS_VERSION) begin
      view.magic[lane32 +: 8] = item.data_byte;
    end else if (pos < fcrc_pkg::POS_LENGTH) begin
      view.version[lane16 +: 8] = item.data_byte;
    end else if (pos < fcrc_pkg::POS_GEN) begin
      view.length[lane16 +: 8] = item.data_byte;
    end else if (pos < fcrc_pkg::CRC_SPAN) begin
      view.generation[lane32 +: 8] = item.data_byte;
    end else if (pos < fcrc_pkg::HDR_BYTES) begin
      view.stored_crc[lane32 +: 8] = item.data_byte;
    end else begin
      view.payload = (pos_off < {1'b0, seen_length});
    end

    if ((pos < fcrc_pkg::CRC_SPAN) || view.payload) begin
      view.running_crc = fcrc_pkg::crc_byte(running_crc, item.data_byte);
    end else begin
      view.running_crc = running_crc;
    end

    pos_next   = (pos != fcrc_pkg::POS_MAX) ? pos + 1'b1 : pos;
    view.count = {1'b0, pos} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      pos             <= '0;
      running_crc     <= fcrc_pkg::CRC_INIT;
      seen_magic      <= '0;
      seen_version    <= '0;
      seen_length     <= '0;
      seen_generation <= '0;
      seen_crc        <= '0;
    end else if (step) begin
      pos             <= pos_next;
      running_crc     <= view.running_crc;
      seen_magic      <= view.magic;
      seen_version    <= view.version;
      seen_length     <= view.length;
      seen_generation <= view.generation;
      seen_crc        <= view.stored_crc;
    end
  end

  `FRC_ASSERT(a_pos_clear, clk, rst, step && item.last_byte |=> pos == '0)
  `FRC_ASSERT_MSG(a_pos_incr, clk, rst,
    step && !item.last_byte && pos != fcrc_pkg::POS_MAX |=> pos == $past(pos) + 1'b1,
    "byte position did not advance")
  `FRC_ASSERT_MSG(a_crc_hold, clk, rst, !step |=> $stable(running_crc) && $stable(pos),
    "state moved without a byte")

endmodule

FILE: rtl/core/fcrc_status.sv
// status evaluation and result formatting for one byte
// depends on fcrc_pkg
module fcrc_status (
  input  fcrc_pkg::hdr_view_t view,
  input  fcrc_pkg::cfg_regs_t cfg,
  input  fcrc_pkg::in_item_t  item,
  output fcrc_pkg::out_item_t result
);

  logic [fcrc_pkg::CNT_W-1:0] need;
  logic                       len_bad;
  logic                       crc_bad;

  always_comb begin
    need    = fcrc_pkg::CNT_W'(fcrc_pkg::HDR_BYTES) + {2'b00, view.length};
    len_bad = (view.length > cfg.payload_capacity) || (need > view.count);
    crc_bad = (~view.running_crc) != view.stored_crc;

    result.out_byte       = view.payload ? item.data_byte : 8'd0;
    result.is_payload     = view.payload;
    result.record_done    = item.last_byte;
    result.status         = fcrc_pkg::ST_OK;
    result.generation     = '0;
    result.payload_length = '0;

    if (item.last_byte) begin
      if (view.count < fcrc_pkg::CNT_W'(fcrc_pkg::HDR_BYTES)) begin
        result.status = fcrc_pkg::ST_SHORT;
      end else begin
        result.generation     = view.generation;
        result.payload_length = view.length;
        if (view.magic != cfg.expected_magic) begin
          result.status = fcrc_pkg::ST_MAGIC;
        end else if (len_bad) begin
          result.status = fcrc_pkg::ST_LENGTH;
        end else if (crc_bad) begin
          result.status = fcrc_pkg::ST_CRC;
        end else if (view.version > cfg.current_version) begin
          result.status = fcrc_pkg::ST_NEWER;
        end else if (view.version < cfg.min_version) begin
          result.status = fcrc_pkg::ST_OLDER;
        end else if ((view.version < cfg.current_version) ||
                     (view.length < cfg.payload_capacity)) begin
          result.status = fcrc_pkg::ST_MIGRATED;
        end else begin
          result.status = fcrc_pkg::ST_OK;
        end
      end
    end
  end

endmodule

FILE: rtl/core/framed_record_crc_checker_top.sv
// framed record crc checker, top level: input register, result register, config
// depends on fcrc_pkg, fcrc_hdr_track, fcrc_status and the assertion macro header
//
// usage: a stored record enters one byte per transfer on the in channel
// (in_valid/in_ready, payload in_data with data_byte and last_byte). the first
// sixteen bytes are a little-endian header (magic, version, length, generation,
// crc); the next length bytes after it are payload. every input transfer gives
// exactly one output transfer (out_valid/out_ready, payload out_data): payload
// bytes come out at once with is_payload set, tentative until the record closes.
// the transfer carrying last_byte closes the record and its result has
// record_done, status, generation and payload_length.
// the staged byte passes from the input register through the combinational crc byte
// update into the result register. throughput: one byte per cycle while out_ready
// stays high, set by that crc byte update.
// stalls: while out_ready is low the result register holds, the input register
// fills behind it, and in_ready drops only when both are full.
// reset (rst, synchronous) empties both registers, clears the header state and
// sets every config register to zero. config writes (cfg_we, cfg_index,
// cfg_wdata) take effect at the clock edge and should be made while idle.
`include "framed_record_crc_checker_top_macros.svh"

module framed_record_crc_checker_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fcrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fcrc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  // input register
  logic               stage_valid;
  fcrc_pkg::in_item_t stage_item;

  // config registers
  fcrc_pkg::cfg_regs_t cfg;

  fcrc_pkg::hdr_view_t view;
  fcrc_pkg::out_item_t result;
  logic                advance;

  // the staged byte moves on when the result register is free or being emptied
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fcrc_pkg::REG_MAGIC:    cfg.expected_magic   <= cfg_wdata;
        fcrc_pkg::REG_CUR_VER:  cfg.current_version  <= cfg_wdata[15:0];
        fcrc_pkg::REG_MIN_VER:  cfg.min_version      <= cfg_wdata[15:0];
        fcrc_pkg::REG_CAPACITY: cfg.payload_capacity <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // header fields and crc including the staged byte
  fcrc_hdr_track u_hdr (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (stage_item),
    .view (view)
  );

  // status priority and result formatting
  fcrc_status u_status (
    .view   (view),
    .cfg    (cfg),
    .item   (stage_item),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  `FRC_ASSERT_MSG(a_ready_low, clk, rst,
    !in_ready |-> stage_valid && out_valid && !out_ready,
    "input refused while a register was free")
  `FRC_ASSERT(a_idle_fields, clk, rst,
    out_valid && !out_data.record_done |->
      out_data.status == fcrc_pkg::ST_OK && out_data.generation == '0 &&
      out_data.payload_length == '0)
  `FRC_ASSERT(a_non_payload, clk, rst,
    out_valid && !out_data.is_payload |-> out_data.out_byte == '0)

endmodule
